// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/wcht_pkg.sv
package wcht_pkg;

	localparam int SUM_W = 16;
	localparam int COUNT_W = 32;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [1:0] ST_EXISTING = 2'd0;
	localparam logic [1:0] ST_NEW      = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_TOO_LONG = 2'd3;

	typedef enum logic [1:0] {
		RES_FULL  = 2'd0,
		RES_LONG  = 2'd1,
		RES_NEW   = 2'd2,
		RES_HIT   = 2'd3
	} res_sel_t;

	typedef struct packed {
		logic     clr_step;
		logic     accept_en;
		logic     hash_step;
		logic     probe_init;
		logic     probe_rd;
		logic     probe_next;
		logic     cmp_init;
		logic     cmp_rd;
		logic     cmp_step;
		logic     new_wr;
		logic     copy_wr;
		logic     res_load;
		res_sel_t res_sel;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic in_fire;
		logic in_last;
		logic too_long;
		logic hash_done;
		logic slot_valid;
		logic len_match;
		logic byte_eq;
		logic cmp_done;
		logic probe_last;
		logic out_free;
	} sts_t;

endpackage

// File: src/wcht_datapath.sv
module wcht_datapath #(
	parameter int TABLE_SLOTS    = 1024,
	parameter int MAX_WORD_BYTES = 64,
	parameter int PROBE_LIMIT    = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  wcht_pkg::cmd_t                 cmd,
	output wcht_pkg::sts_t                 sts,
	input  logic                           in_valid,
	input  logic [7:0]                     char_code,
	input  logic                           last_char,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [$clog2(TABLE_SLOTS)-1:0] slot_index,
	output logic [wcht_pkg::COUNT_W-1:0]   word_count,
	output logic [1:0]                     status
);

	localparam int SLOT_W = $clog2(TABLE_SLOTS);
	localparam int IDX_W = $clog2(MAX_WORD_BYTES);
	localparam int LEN_W = $clog2(MAX_WORD_BYTES + 1);
	localparam int SUM_W = wcht_pkg::SUM_W;
	localparam int CNT_W = wcht_pkg::COUNT_W;
	localparam int RK    = SUM_W + SLOT_W;
	localparam int WIDE_W = SUM_W + SLOT_W + 1;
	localparam int HASH_STEPS = 3;
	localparam int HC_W  = 2;
	localparam int PRB_W = $clog2(PROBE_LIMIT + 1);
	localparam int SLOTS_P2 = 1 << SLOT_W;
	localparam int KEY_DEPTH = 1 << (SLOT_W + IDX_W);
	localparam logic [SLOT_W:0] SLOTS_V = (SLOT_W + 1)'(TABLE_SLOTS);
	localparam logic [WIDE_W-1:0] SLOTS_WV = WIDE_W'(TABLE_SLOTS);
	localparam logic [SUM_W:0] RECIP = (SUM_W + 1)'((64'd1 << RK) / 64'(TABLE_SLOTS));
	localparam logic [LEN_W-1:0] MAX_V = LEN_W'(MAX_WORD_BYTES);

	logic [7:0]        buf_mem [MAX_WORD_BYTES];
	logic [LEN_W:0]    meta_mem [SLOTS_P2];
	logic [CNT_W-1:0]  cnt_mem [SLOTS_P2];
	logic [7:0]        key_mem [KEY_DEPTH];

	logic [LEN_W-1:0]  len_q;
	logic              too_long_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [HC_W-1:0]   hcnt_q;
	logic [SLOT_W-1:0] clr_q;
	logic [SLOT_W-1:0] h_q;
	logic [SLOT_W-1:0] sq_q;
	logic [SLOT_W-1:0] odd_q;
	logic [PRB_W-1:0]  prb_q;
	logic [LEN_W-1:0]  i_q;
	logic [LEN_W:0]    meta_rd_q;
	logic [CNT_W-1:0]  cnt_rd_q;
	logic [7:0]        key_rd_q;
	logic [7:0]        buf_rd_q;
	logic              out_valid_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [CNT_W-1:0]  res_cnt_q;
	logic [1:0]        res_st_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic [1:0]        out_st_q;

	logic              in_fire;
	logic [SUM_W-1:0]  sum_next;
	logic [2*SUM_W:0]  prod;
	logic [WIDE_W-1:0] rem_ext;
	logic [WIDE_W-1:0] qn;
	logic [WIDE_W-1:0] rem_sub;
	logic [SLOT_W:0]   sq_sum;
	logic [SLOT_W-1:0] sq_next;
	logic [SLOT_W:0]   h_sum;
	logic [SLOT_W-1:0] h_next;
	logic [SLOT_W:0]   odd_sum;
	logic [SLOT_W-1:0] odd_next;
	logic [CNT_W-1:0]  cnt_inc;
	logic [IDX_W-1:0]  i_idx;

	assign in_fire  = cmd.accept_en && in_valid;
	assign sum_next = sum_q + SUM_W'(char_code);
	assign i_idx    = i_q[IDX_W-1:0];

	// The slot is the sum minus an estimated quotient times the table size, then one correction.
	assign prod    = {{(SUM_W + 1){1'b0}}, rem_q} * {{SUM_W{1'b0}}, RECIP};
	assign rem_ext = WIDE_W'(rem_q);
	assign qn      = WIDE_W'(quo_q) * SLOTS_WV;
	assign rem_sub = rem_ext - qn;

	assign sq_sum   = {1'b0, sq_q} + {1'b0, odd_q};
	assign sq_next  = (sq_sum >= SLOTS_V) ? SLOT_W'(sq_sum - SLOTS_V) : sq_sum[SLOT_W-1:0];
	assign h_sum    = {1'b0, h_q} + {1'b0, sq_next};
	assign h_next   = (h_sum >= SLOTS_V) ? SLOT_W'(h_sum - SLOTS_V) : h_sum[SLOT_W-1:0];
	assign odd_sum  = {1'b0, odd_q} + (SLOT_W + 1)'(2);
	assign odd_next = (odd_sum >= SLOTS_V) ? SLOT_W'(odd_sum - SLOTS_V) : odd_sum[SLOT_W-1:0];
	assign cnt_inc  = (cnt_rd_q == wcht_pkg::COUNT_MAX) ? cnt_rd_q : cnt_rd_q + CNT_W'(1);

	assign sts.clear_done = (clr_q == SLOT_W'(TABLE_SLOTS - 1));
	assign sts.in_fire    = in_fire;
	assign sts.in_last    = last_char;
	assign sts.too_long   = too_long_q || (len_q == MAX_V);
	assign sts.hash_done  = (hcnt_q == '0);
	assign sts.slot_valid = meta_rd_q[LEN_W];
	assign sts.len_match  = (meta_rd_q[LEN_W-1:0] == len_q);
	assign sts.byte_eq    = (key_rd_q == buf_rd_q);
	assign sts.cmp_done   = (i_q == len_q);
	assign sts.probe_last = (prb_q == PRB_W'(PROBE_LIMIT - 1));
	assign sts.out_free   = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			too_long_q  <= 1'b0;
			sum_q       <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + SLOT_W'(1);
			end
			if (in_fire) begin
				if (len_q < MAX_V) begin
					len_q <= len_q + LEN_W'(1);
					sum_q <= sum_next;
				end else begin
					too_long_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				len_q      <= '0;
				too_long_q <= 1'b0;
				sum_q      <= '0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && len_q < MAX_V) begin
			buf_mem[len_q[IDX_W-1:0]] <= char_code;
		end
		if (in_fire) begin
			rem_q  <= (len_q < MAX_V) ? sum_next : sum_q;
			hcnt_q <= HC_W'(HASH_STEPS);
		end else if (cmd.hash_step) begin
			if (hcnt_q == HC_W'(HASH_STEPS)) begin
				quo_q <= SUM_W'(prod >> RK);
			end else if (hcnt_q == HC_W'(HASH_STEPS - 1)) begin
				rem_q <= SUM_W'(rem_sub);
			end else if (rem_ext >= SLOTS_WV) begin
				rem_q <= SUM_W'(rem_ext - SLOTS_WV);
			end
			hcnt_q <= hcnt_q - HC_W'(1);
		end
		if (cmd.probe_init) begin
			h_q   <= SLOT_W'(rem_q);
			sq_q  <= '0;
			odd_q <= SLOT_W'(1);
			prb_q <= '0;
		end else if (cmd.probe_next) begin
			h_q   <= h_next;
			sq_q  <= sq_next;
			odd_q <= odd_next;
			prb_q <= prb_q + PRB_W'(1);
		end
		if (cmd.clr_step) begin
			meta_mem[clr_q] <= '0;
		end else if (cmd.new_wr) begin
			meta_mem[h_q] <= {1'b1, len_q};
		end
		if (cmd.new_wr) begin
			cnt_mem[h_q] <= CNT_W'(1);
		end else if (cmd.res_load && cmd.res_sel == wcht_pkg::RES_HIT) begin
			cnt_mem[h_q] <= cnt_inc;
		end
		if (cmd.probe_rd) begin
			meta_rd_q <= meta_mem[h_q];
			cnt_rd_q  <= cnt_mem[h_q];
		end
		if (cmd.cmp_init) begin
			i_q <= '0;
		end else if (cmd.cmp_step) begin
			i_q <= i_q + LEN_W'(1);
		end
		if (cmd.cmp_rd) begin
			key_rd_q <= key_mem[{h_q, i_idx}];
			buf_rd_q <= buf_mem[i_idx];
		end
		if (cmd.copy_wr) begin
			key_mem[{h_q, i_idx}] <= buf_rd_q;
		end
		if (cmd.res_load) begin
			case (cmd.res_sel)
				wcht_pkg::RES_HIT: begin
					res_slot_q <= h_q;
					res_cnt_q  <= cnt_inc;
					res_st_q   <= wcht_pkg::ST_EXISTING;
				end
				wcht_pkg::RES_NEW: begin
					res_slot_q <= h_q;
					res_cnt_q  <= CNT_W'(1);
					res_st_q   <= wcht_pkg::ST_NEW;
				end
				wcht_pkg::RES_LONG: begin
					res_slot_q <= '0;
					res_cnt_q  <= '0;
					res_st_q   <= wcht_pkg::ST_TOO_LONG;
				end
				default: begin
					res_slot_q <= '0;
					res_cnt_q  <= '0;
					res_st_q   <= wcht_pkg::ST_FULL;
				end
			endcase
		end
		if (cmd.emit) begin
			out_slot_q <= res_slot_q;
			out_cnt_q  <= res_cnt_q;
			out_st_q   <= res_st_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign slot_index = out_slot_q;
	assign word_count = out_cnt_q;
	assign status     = out_st_q;

endmodule

// File: src/wcht_ctrl.sv
module wcht_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  wcht_pkg::sts_t  sts,
	output wcht_pkg::cmd_t  cmd
);

	typedef enum logic [10:0] {
		S_CLEAR     = 11'b00000000001,
		S_IDLE      = 11'b00000000010,
		S_HASH      = 11'b00000000100,
		S_PROBE_RD  = 11'b00000001000,
		S_PROBE_CHK = 11'b00000010000,
		S_CMP_RD    = 11'b00000100000,
		S_CMP_CHK   = 11'b00001000000,
		S_HIT       = 11'b00010000000,
		S_COPY_RD   = 11'b00100000000,
		S_COPY_WR   = 11'b01000000000,
		S_EMIT      = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.res_sel = wcht_pkg::RES_FULL;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clear_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.accept_en = 1'b1;
				if (sts.in_fire && sts.in_last) begin
					if (sts.too_long) begin
						cmd.res_load = 1'b1;
						cmd.res_sel  = wcht_pkg::RES_LONG;
						state_d      = S_EMIT;
					end else begin
						state_d = S_HASH;
					end
				end
			end
			S_HASH: begin
				if (sts.hash_done) begin
					cmd.probe_init = 1'b1;
					state_d        = S_PROBE_RD;
				end else begin
					cmd.hash_step = 1'b1;
				end
			end
			S_PROBE_RD: begin
				cmd.probe_rd = 1'b1;
				state_d      = S_PROBE_CHK;
			end
			S_PROBE_CHK: begin
				cmd.cmp_init = 1'b1;
				if (!sts.slot_valid) begin
					cmd.new_wr = 1'b1;
					state_d    = S_COPY_RD;
				end else if (sts.len_match) begin
					state_d = S_CMP_RD;
				end else if (sts.probe_last) begin
					cmd.res_load = 1'b1;
					state_d      = S_EMIT;
				end else begin
					cmd.probe_next = 1'b1;
					state_d        = S_PROBE_RD;
				end
			end
			S_CMP_RD: begin
				if (sts.cmp_done) begin
					state_d = S_HIT;
				end else begin
					cmd.cmp_rd = 1'b1;
					state_d    = S_CMP_CHK;
				end
			end
			S_CMP_CHK: begin
				if (sts.byte_eq) begin
					cmd.cmp_step = 1'b1;
					state_d      = S_CMP_RD;
				end else if (sts.probe_last) begin
					cmd.res_load = 1'b1;
					state_d      = S_EMIT;
				end else begin
					cmd.probe_next = 1'b1;
					state_d        = S_PROBE_RD;
				end
			end
			S_HIT: begin
				cmd.res_load = 1'b1;
				cmd.res_sel  = wcht_pkg::RES_HIT;
				state_d      = S_EMIT;
			end
			S_COPY_RD: begin
				if (sts.cmp_done) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = wcht_pkg::RES_NEW;
					state_d      = S_EMIT;
				end else begin
					cmd.cmp_rd = 1'b1;
					state_d    = S_COPY_WR;
				end
			end
			S_COPY_WR: begin
				cmd.copy_wr  = 1'b1;
				cmd.cmp_step = 1'b1;
				state_d      = S_COPY_RD;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: src/word_count_hash_table.sv
// Bytes are taken one per cycle while in_stall is low; a byte that does not end a word
// causes no result. After the last byte of a word that is not too long, the sum is
// hashed to a slot and slots are probed; the key bytes are compared for a counted word
// or copied for a new one. No byte is taken until the result is loaded for output.
// After reset, the slot valid bits are cleared slot by slot before the first byte is taken.
module word_count_hash_table #(
	parameter int TABLE_SLOTS    = 1024,
	parameter int MAX_WORD_BYTES = 64,
	parameter int PROBE_LIMIT    = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    char_code,
	input  logic                          last_char,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [$clog2(TABLE_SLOTS)-1:0] slot_index,
	output logic [wcht_pkg::COUNT_W-1:0]  word_count,
	output logic [1:0]                    status
);

	localparam int SLOT_W = $clog2(TABLE_SLOTS);

	wcht_pkg::cmd_t cmd;
	wcht_pkg::sts_t sts;

	assign in_stall = !cmd.accept_en;

	wcht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	wcht_datapath #(
		.TABLE_SLOTS    (TABLE_SLOTS),
		.MAX_WORD_BYTES (MAX_WORD_BYTES),
		.PROBE_LIMIT    (PROBE_LIMIT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_valid   (in_valid),
		.char_code  (char_code),
		.last_char  (last_char),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.slot_index (slot_index),
		.word_count (word_count),
		.status     (status)
	);

endmodule

// File: src/wcht_checker.sv
`include "assert_macros.svh"

module wcht_checker #(
	parameter int SLOT_W = 10
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [SLOT_W-1:0]             slot_index,
	input logic [wcht_pkg::COUNT_W-1:0]  word_count,
	input logic [1:0]                    status
);

	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(slot_index) && $stable(word_count) && $stable(status), "stalled result changed")
	`ASSERT_SAME(a_fail_zero, out_valid && (status == wcht_pkg::ST_FULL || status == wcht_pkg::ST_TOO_LONG), slot_index == '0 && word_count == '0, "failed item has nonzero fields")
	`ASSERT_SAME(a_new_one, out_valid && status == wcht_pkg::ST_NEW, word_count == wcht_pkg::COUNT_W'(1), "new entry count is not one")
	`ASSERT_SAME(a_hit_count, out_valid && status == wcht_pkg::ST_EXISTING, word_count > wcht_pkg::COUNT_W'(1), "repeated word count too small")

endmodule

bind word_count_hash_table wcht_checker #(.SLOT_W(SLOT_W)) u_wcht_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.slot_index (slot_index),
	.word_count (word_count),
	.status     (status)
);
